>>> rtl/dgsp_pkg.sv
// Shared types, widths and constants for the dense-graph shortest-path block.
// Used by every module of the block and by its checker; depends on nothing.
package dgsp_pkg;

    localparam int VERTICES    = 8;
    localparam int WEIGHT_BITS = 8;

    // Fixed field widths of the stream items.
    localparam int VERT_W      = 3;
    localparam int WEIGHT_IN_W = 8;
    localparam int DIST_W      = 11;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 16;

    localparam int IDX_W  = (VERTICES > 1) ? $clog2(VERTICES) : 1;
    localparam int ADDR_W = $clog2(VERTICES * VERTICES);
    // Wide enough for any simple path: each of its edges, fewer than the vertices, has at most the largest weight.
    localparam int SUM_W  = WEIGHT_BITS + IDX_W;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_RUN   = 1'b1;

    typedef struct packed {
        logic [VERT_W-1:0] vertex;
        logic [DIST_W-1:0] distance;
        logic              unreachable;
        logic              last;
    } t_result;

    function automatic logic [DIST_W-1:0] sat_dist(input logic [SUM_W-1:0] d);
        logic [DIST_W-1:0] res;
        if (64'(d) > 64'(DIST_MAX)) begin
            res = DIST_MAX;
        end else begin
            res = DIST_W'(d);
        end
        return res;
    endfunction

endpackage

>>> rtl/dgsp_edge_mem.sv
// Adjacency matrix storage: one write port, one registered read port.
// Per-entry valid bits make the whole matrix read as zero right after reset.
// Depends on dgsp_pkg.
module dgsp_edge_mem (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_we,
    input  logic [dgsp_pkg::ADDR_W-1:0]      i_waddr,
    input  logic [dgsp_pkg::WEIGHT_BITS-1:0] i_wdata,
    input  logic [dgsp_pkg::ADDR_W-1:0]      i_raddr,
    output logic [dgsp_pkg::WEIGHT_BITS-1:0] o_rdata
);
    import dgsp_pkg::*;

    logic [WEIGHT_BITS-1:0]    r_mem [VERTICES*VERTICES];
    logic [VERTICES*VERTICES-1:0] r_valid;
    logic [WEIGHT_BITS-1:0]    r_rd_data;
    logic                      r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd_data <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            r_rd_valid <= r_valid[i_raddr];
        end
    end

    assign o_rdata = r_rd_valid ? r_rd_data : '0;

endmodule

>>> rtl/dgsp_core.sv
// Round sequencer for the shortest-path search: minimum scan and relaxation
// through one shared adder and one shared comparator, then result emission.
// Depends on dgsp_pkg; reads the matrix through dgsp_edge_mem's read port.
module dgsp_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [dgsp_pkg::IDX_W-1:0]       i_src,
    output logic                             o_idle,
    output logic [dgsp_pkg::ADDR_W-1:0]      o_raddr,
    input  logic [dgsp_pkg::WEIGHT_BITS-1:0] i_rdata,
    output logic                             o_res_valid,
    input  logic                             i_res_ready,
    output dgsp_pkg::t_result                o_res
);
    import dgsp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_RELAX = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    logic [VERTICES-1:0] r_reach, n_reach;
    logic [VERTICES-1:0] r_visited, n_visited;
    logic [IDX_W-1:0]    r_round, n_round;
    logic [IDX_W-1:0]    r_v, n_v;
    logic [IDX_W:0]      r_rv, n_rv;
    logic [IDX_W-1:0]    r_best, n_best;
    logic [SUM_W-1:0]    r_bd, n_bd;
    logic                r_breach, n_breach;
    logic                r_have, n_have;
    logic [IDX_W-1:0]    r_u, n_u;
    logic [SUM_W-1:0]    r_du, n_du;

    logic [SUM_W-1:0]    r_dist [VERTICES];

    logic [IDX_W-1:0]    vd;
    logic [IDX_W-1:0]    dist_ra;
    logic [SUM_W-1:0]    dist_rd;
    logic                dist_we;
    logic [IDX_W-1:0]    dist_wa;
    logic [SUM_W-1:0]    dist_wd;
    logic [SUM_W-1:0]    cand;
    logic [SUM_W-1:0]    cmp_a, cmp_b;
    logic                cmp_lt;
    logic                take;
    logic                round_done;
    logic                upd;

    // The vertex whose relaxation result arrives this cycle is one index below the vertex now being read.
    assign vd = IDX_W'(r_rv - 1'b1);

    always_comb begin
        unique case (r_state)
            S_RELAX: dist_ra = vd;
            S_EMIT:  dist_ra = r_v;
            default: dist_ra = r_v;
        endcase
    end

    assign dist_rd = r_dist[dist_ra];

    // Shared datapath: one adder and one less-than compare.
    assign cand   = r_du + SUM_W'(i_rdata);
    assign cmp_a  = (r_state == S_RELAX) ? cand : r_bd;
    assign cmp_b  = dist_rd;
    assign cmp_lt = cmp_a < cmp_b;

    assign o_raddr = ADDR_W'(r_u) * ADDR_W'(VERTICES) + ADDR_W'(r_rv[IDX_W-1:0]);

    always_comb begin
        n_state    = r_state;
        n_reach    = r_reach;
        n_visited  = r_visited;
        n_round    = r_round;
        n_v        = r_v;
        n_rv       = r_rv;
        n_best     = r_best;
        n_bd       = r_bd;
        n_breach   = r_breach;
        n_have     = r_have;
        n_u        = r_u;
        n_du       = r_du;
        dist_we    = 1'b0;
        dist_wa    = r_v;
        dist_wd    = cand;
        round_done = 1'b0;
        take       = 1'b0;
        upd        = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_reach        = '0;
                    n_reach[i_src] = 1'b1;
                    n_visited      = '0;
                    n_round        = '0;
                    n_v            = '0;
                    n_have         = 1'b0;
                    dist_we        = 1'b1;
                    dist_wa        = i_src;
                    dist_wd        = '0;
                    n_state        = S_SCAN;
                end
            end
            S_SCAN: begin
                // An unreachable current best loses to any later unvisited vertex;
                // among reachable ones the later index wins a tie.
                take = !r_visited[r_v] &&
                       (!r_have || !r_breach || (r_reach[r_v] && !cmp_lt));
                if (take) begin
                    n_best   = r_v;
                    n_bd     = dist_rd;
                    n_breach = r_reach[r_v];
                    n_have   = 1'b1;
                end
                if (r_v == IDX_W'(VERTICES - 1)) begin
                    n_visited[n_best] = 1'b1;
                    n_u               = n_best;
                    n_du              = n_bd;
                    n_rv              = '0;
                    if (n_breach) begin
                        n_state = S_RELAX;
                    end else begin
                        round_done = 1'b1;
                    end
                end else begin
                    n_v = r_v + 1'b1;
                end
            end
            S_RELAX: begin
                if (r_rv != '0) begin
                    upd = !r_visited[vd] && (i_rdata != '0) && (!r_reach[vd] || cmp_lt);
                    if (upd) begin
                        dist_we     = 1'b1;
                        dist_wa     = vd;
                        dist_wd     = cand;
                        n_reach[vd] = 1'b1;
                    end
                end
                if (r_rv == (IDX_W+1)'(VERTICES)) begin
                    round_done = 1'b1;
                end else begin
                    n_rv = r_rv + 1'b1;
                end
            end
            S_EMIT: begin
                if (i_res_ready) begin
                    if (r_v == IDX_W'(VERTICES - 1)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_v = r_v + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (round_done) begin
            n_v    = '0;
            n_have = 1'b0;
            if (r_round == IDX_W'(VERTICES - 2)) begin
                n_state = S_EMIT;
            end else begin
                n_round = r_round + 1'b1;
                n_state = S_SCAN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_reach   <= '0;
            r_visited <= '0;
            r_round   <= '0;
            r_v       <= '0;
            r_rv      <= '0;
            r_have    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_reach   <= n_reach;
            r_visited <= n_visited;
            r_round   <= n_round;
            r_v       <= n_v;
            r_rv      <= n_rv;
            r_have    <= n_have;
        end
    end

    always_ff @(posedge i_clk) begin
        r_best   <= n_best;
        r_bd     <= n_bd;
        r_breach <= n_breach;
        r_u      <= n_u;
        r_du     <= n_du;
        if (dist_we) begin
            r_dist[dist_wa] <= dist_wd;
        end
    end

    assign o_idle      = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_EMIT);

    always_comb begin
        o_res.vertex      = VERT_W'(r_v);
        o_res.distance    = r_reach[r_v] ? sat_dist(dist_rd) : '0;
        o_res.unreachable = !r_reach[r_v];
        o_res.last        = (r_v == IDX_W'(VERTICES - 1));
    end

endmodule

>>> rtl/dense_graph_shortest_paths.sv
// Dense-graph shortest paths (Dijkstra over a stored adjacency matrix).
// Input items arrive on the s_axis channel, results leave on m_axis.
// s_axis_tuser is the command: a write item stores one edge weight (zero means
// no edge); a run item computes distances from start_vertex.
// A run takes a setup step, then VERTICES-1 rounds of a minimum scan over all
// vertices, each followed by a relaxation pass when the picked vertex is
// reachable; then VERTICES results, one per cycle while the receiver takes
// them, in vertex order with tlast on the final one. The search pace is set
// by the shared compare/add unit, which handles one vertex per cycle, and by
// the single read port of the matrix memory.
// s_axis_tready is high only while no run is in progress; the last result of
// a run may still sit in the output register while the next item is taken.
// When the receiver stalls, the current result holds in the output register
// and the search pauses its emission until it is taken.
// Reset clears the matrix at once through per-entry valid bits (no clearing
// pass) and empties the output register.
// Depends on dgsp_pkg, dgsp_edge_mem and dgsp_core.
module dense_graph_shortest_paths (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata: row[2:0], col[5:3], weight[13:6], start_vertex[16:14], zero pad
    input  logic [dgsp_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // tuser: cmd
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata: vertex[2:0], distance[13:3], zero pad
    output logic [dgsp_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // tuser: unreachable
    output logic                               m_axis_tuser,
    output logic                               m_axis_tlast
);
    import dgsp_pkg::*;

    logic [VERT_W-1:0]      in_row, in_col, in_start;
    logic [WEIGHT_IN_W-1:0] in_weight;
    logic                   accept;
    logic                   wr_en, run_en;
    logic [ADDR_W-1:0]      waddr, raddr;
    logic [WEIGHT_BITS-1:0] rdata;
    logic                   core_idle;
    logic                   res_valid, res_ready;
    t_result                res;
    logic                   r_mvalid;
    t_result                r_mres;

    assign in_row    = s_axis_tdata[VERT_W-1:0];
    assign in_col    = s_axis_tdata[2*VERT_W-1:VERT_W];
    assign in_weight = s_axis_tdata[2*VERT_W+WEIGHT_IN_W-1:2*VERT_W];
    assign in_start  = s_axis_tdata[3*VERT_W+WEIGHT_IN_W-1:2*VERT_W+WEIGHT_IN_W];

    assign s_axis_tready = core_idle;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Items naming a vertex beyond the graph are taken and dropped.
    assign wr_en  = accept && (s_axis_tuser == CMD_WRITE) &&
                    (32'(in_row) < VERTICES) && (32'(in_col) < VERTICES);
    assign run_en = accept && (s_axis_tuser == CMD_RUN) && (32'(in_start) < VERTICES);

    assign waddr = ADDR_W'(in_row) * ADDR_W'(VERTICES) + ADDR_W'(in_col);

    dgsp_edge_mem u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (wr_en),
        .i_waddr (waddr),
        .i_wdata (WEIGHT_BITS'(in_weight)),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    dgsp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (run_en),
        .i_src       (IDX_W'(in_start)),
        .o_idle      (core_idle),
        .o_raddr     (raddr),
        .i_rdata     (rdata),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    assign res_ready = !r_mvalid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvalid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_mvalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_mvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_mres <= res;
        end
    end

    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = OUT_TDATA_W'({r_mres.distance, r_mres.vertex});
    assign m_axis_tuser  = r_mres.unreachable;
    assign m_axis_tlast  = r_mres.last;

endmodule

>>> rtl/dgsp_checker.sv
// Port-level checker for dense_graph_shortest_paths, bound to the top level.
// Depends on dgsp_pkg.
module dgsp_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [dgsp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input logic                             s_axis_tuser,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [dgsp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                             m_axis_tuser,
    input logic                             m_axis_tlast
);
    import dgsp_pkg::*;

    // A stalled result holds its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // An unreachable vertex reports a zero distance.
    a_unreach_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[VERT_W+DIST_W-1:VERT_W] == '0)
        else $error("unreachable result with nonzero distance");

    // The final result of a run belongs to the highest vertex.
    a_last_vertex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[VERT_W-1:0] == VERT_W'(VERTICES - 1))
        else $error("tlast on a result other than the highest vertex");

    // A taken run item with a valid start vertex closes the input as the search starts.
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_RUN
            && 32'(s_axis_tdata[IN_TDATA_W-1-(IN_TDATA_W-3*VERT_W-WEIGHT_IN_W):
                                2*VERT_W+WEIGHT_IN_W]) < VERTICES
        |=> !s_axis_tready)
        else $error("input open right after a run item");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind dense_graph_shortest_paths dgsp_checker u_dgsp_checker (.*);
